### rtl/core/clabf_pkg.sv
// Package for the lens aberration filter: widths, register codes, payload types, CORDIC table.
`timescale 1ns / 1ps
`default_nettype none
package clabf_pkg;

    // Field widths
    localparam int FREQ_W   = 24;
    localparam int SAMPLE_W = 32;
    localparam int LIMIT_W  = 24;
    localparam int COEF_W   = 32;
    localparam int ANGLE_W  = 16;
    localparam int FRAC_SH  = 20;

    // CORDIC
    localparam int CORDIC_STEPS = 15;
    localparam int ROT_W        = 32;
    localparam int ROT_FRAC     = 30;
    localparam int SIN_DROP     = 10;
    localparam logic signed [ROT_W-1:0] CORDIC_X0 = 32'sd652032874;

    // Phase to binary angle scale
    localparam int TS_W = 30;
    localparam logic [TS_W-1:0] TURN_SCALE = 30'd683565276;

    // Square root sizing: only k^2 below the largest limit matters
    localparam int SQ_IN_W = LIMIT_W + FRAC_SH;
    localparam int ROOT_W  = SQ_IN_W / 2;
    localparam int K2_W    = SQ_IN_W - FRAC_SH;

    // Pipeline latencies
    localparam int SQRT_LAT = ROOT_W;
    localparam int VEC_LAT  = CORDIC_STEPS + 1;
    localparam int ROT_LAT  = CORDIC_STEPS + 2;
    localparam int PH_LAT   = ROT_LAT + 4;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_APERTURE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THIRD      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIFTH      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEFOCUS    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TWOFOLD    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TWO_ANGLE  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THREEFOLD  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_THREE_ANGLE = 4'd7;

    typedef struct packed {
        logic signed [FREQ_W-1:0]   freq_x;
        logic signed [FREQ_W-1:0]   freq_y;
        logic signed [SAMPLE_W-1:0] wave_real;
        logic signed [SAMPLE_W-1:0] wave_imag;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered_real;
        logic signed [SAMPLE_W-1:0] filtered_imag;
        logic                       inside_aperture;
    } out_t;

    typedef struct packed {
        logic [LIMIT_W-1:0]       aperture_k2_limit;
        logic signed [COEF_W-1:0] third_order_coef;
        logic signed [COEF_W-1:0] fifth_order_coef;
        logic signed [COEF_W-1:0] defocus_coef;
        logic signed [COEF_W-1:0] twofold_coef;
        logic [ANGLE_W-1:0]       twofold_angle;
        logic signed [COEF_W-1:0] threefold_coef;
        logic [ANGLE_W-1:0]       threefold_angle;
    } cfg_t;

    // atan(2^-i) as a binary angle
    function automatic logic [ANGLE_W-1:0] atan_step(input int i);
        logic [ANGLE_W-1:0] a;
        case (i)
            0:       a = 16'd8192;
            1:       a = 16'd4836;
            2:       a = 16'd2555;
            3:       a = 16'd1297;
            4:       a = 16'd651;
            5:       a = 16'd326;
            6:       a = 16'd163;
            7:       a = 16'd81;
            8:       a = 16'd41;
            9:       a = 16'd20;
            10:      a = 16'd10;
            11:      a = 16'd5;
            12:      a = 16'd3;
            13:      a = 16'd1;
            14:      a = 16'd1;
            default: a = 16'd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

### rtl/core/clabf_isqrt.sv
// Pipelined floor square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module clabf_isqrt (
    input  wire logic                           clk,
    input  wire logic [clabf_pkg::SQ_IN_W-1:0]  val,
    output logic      [clabf_pkg::ROOT_W-1:0]   root
);
    import clabf_pkg::*;

    localparam int IN_W  = SQ_IN_W;
    localparam int REM_W = ROOT_W + 2;

    logic [REM_W-1:0]  rem_reg  [ROOT_W-1];
    logic [IN_W-1:0]   rest_reg [ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_st
        logic [REM_W-1:0]  rem_in;
        logic [REM_W-1:0]  cand;
        logic [REM_W-1:0]  trial;
        logic [ROOT_W-1:0] root_in;
        logic [IN_W-1:0]   rest_in;
        logic              take;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rest_in = val;
        end
        else begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign rest_in = rest_reg[s-1];
        end

        // bring down the next two bits and try the next root bit
        assign cand  = {rem_in[REM_W-3:0], rest_in[IN_W-1 -: 2]};
        assign trial = {root_in, 2'b01};
        assign take  = (cand >= trial);

        always_ff @(posedge clk)
        begin
            root_reg[s] <= {root_in[ROOT_W-2:0], take};
        end

        if (s < ROOT_W - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[s]  <= take ? (cand - trial) : cand;
                rest_reg[s] <= {rest_in[IN_W-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule
`default_nettype wire

### rtl/core/clabf_vec.sv
// Pipelined CORDIC vectoring: binary angle of (fy, fx), zero at the origin.
`timescale 1ns / 1ps
`default_nettype none
module clabf_vec (
    input  wire logic                                clk,
    input  wire logic signed [clabf_pkg::FREQ_W-1:0] fx,
    input  wire logic signed [clabf_pkg::FREQ_W-1:0] fy,
    output logic             [clabf_pkg::ANGLE_W-1:0] phi
);
    import clabf_pkg::*;

    // headroom for the half-turn fold and CORDIC growth
    localparam int VW = FREQ_W + 3;
    localparam logic [ANGLE_W-1:0] HALF_TURN = 16'h8000;

    logic signed [VW-1:0]      x_reg [CORDIC_STEPS+1];
    logic signed [VW-1:0]      y_reg [CORDIC_STEPS+1];
    logic        [ANGLE_W-1:0] z_reg [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0]     zero_reg;
    logic signed [VW-1:0]      fxe;
    logic signed [VW-1:0]      fye;

    assign fxe = VW'(fx);
    assign fye = VW'(fy);

    // fold the left half plane by a half turn
    always_ff @(posedge clk)
    begin
        if (fx[FREQ_W-1]) begin
            x_reg[0] <= -fxe;
            y_reg[0] <= -fye;
            z_reg[0] <= HALF_TURN;
        end
        else begin
            x_reg[0] <= fxe;
            y_reg[0] <= fye;
            z_reg[0] <= '0;
        end
        zero_reg[0] <= (fx == '0) && (fy == '0);
    end

    // one micro-rotation per stage, driving y to zero
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge clk)
        begin
            if (!y_reg[i][VW-1]) begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + atan_step(i);
            end
            else begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - atan_step(i);
            end
            zero_reg[i+1] <= zero_reg[i];
        end
    end

    assign phi = zero_reg[CORDIC_STEPS] ? '0 : z_reg[CORDIC_STEPS];

endmodule
`default_nettype wire

### rtl/core/clabf_rot.sv
// Pipelined CORDIC rotation: cosine and sine of a binary angle, Q2.30.
`timescale 1ns / 1ps
`default_nettype none
module clabf_rot (
    input  wire logic                                clk,
    input  wire logic        [clabf_pkg::ANGLE_W-1:0] ang,
    output logic signed      [clabf_pkg::ROT_W-1:0]   cos,
    output logic signed      [clabf_pkg::ROT_W-1:0]   sin
);
    import clabf_pkg::*;

    localparam int Z_W = ANGLE_W + 2;
    localparam logic signed [Z_W-1:0] QTR_TURN  = Z_W'(16384);
    localparam logic signed [Z_W-1:0] HALF_TURN = Z_W'(32768);

    logic signed [ROT_W-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [ROT_W-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]   z_reg [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0]   neg_reg;
    logic signed [Z_W-1:0]   za;
    logic signed [ROT_W-1:0] cos_reg;
    logic signed [ROT_W-1:0] sin_reg;

    assign za = Z_W'($signed(ang));

    // fold into the right half plane
    always_ff @(posedge clk)
    begin
        x_reg[0] <= CORDIC_X0;
        y_reg[0] <= '0;
        if (za > QTR_TURN) begin
            z_reg[0]   <= za - HALF_TURN;
            neg_reg[0] <= 1'b1;
        end
        else if (za < -QTR_TURN) begin
            z_reg[0]   <= za + HALF_TURN;
            neg_reg[0] <= 1'b1;
        end
        else begin
            z_reg[0]   <= za;
            neg_reg[0] <= 1'b0;
        end
    end

    // micro-rotations driving z to zero
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [Z_W-1:0] at;
        assign at = $signed(Z_W'(atan_step(i)));
        always_ff @(posedge clk)
        begin
            if (!z_reg[i][Z_W-1]) begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - at;
            end
            else begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + at;
            end
            neg_reg[i+1] <= neg_reg[i];
        end
    end

    // undo the fold
    always_ff @(posedge clk)
    begin
        cos_reg <= neg_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
        sin_reg <= neg_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
    end

    assign cos = cos_reg;
    assign sin = sin_reg;

endmodule
`default_nettype wire

### rtl/core/clabf_phase.sv
// Aberration phase pipeline: k powers, chi terms, conversion to a binary angle.
`timescale 1ns / 1ps
`default_nettype none
module clabf_phase (
    input  wire logic                               clk,
    input  wire clabf_pkg::cfg_t                    cfg,
    input  wire logic [clabf_pkg::K2_W-1:0]         k2,
    input  wire logic [clabf_pkg::ROOT_W-1:0]       k,
    input  wire logic [clabf_pkg::ANGLE_W-1:0]      phi,
    output logic      [clabf_pkg::ANGLE_W-1:0]      ang
);
    import clabf_pkg::*;

    localparam int K4P_W = 2 * K2_W;
    localparam int K4_W  = K4P_W - FRAC_SH;
    localparam int K3P_W = K2_W + ROOT_W;
    localparam int K3_W  = K3P_W - FRAC_SH;
    localparam int K6P_W = K4_W + K2_W;
    localparam int K6_W  = K6P_W - FRAC_SH;
    localparam int M3_W  = COEF_W + K4_W + 1;
    localparam int M5_W  = COEF_W + K6_W + 1;
    localparam int MD_W  = COEF_W + K2_W + 1;
    localparam int M3T_W = COEF_W + K3_W + 1;
    localparam int T2_W  = MD_W - FRAC_SH;
    localparam int T3_W  = M3T_W - FRAC_SH;
    localparam int SQ_W  = ROT_W - SIN_DROP;
    localparam int Q2_W  = T2_W + SQ_W;
    localparam int Q3_W  = T3_W + SQ_W;
    localparam int CHI_W = 48;
    localparam int HALF_CHI = CHI_W / 2;
    localparam int PL_W  = HALF_CHI + TS_W;
    localparam int POLY_DLY = ROT_LAT - 3;
    localparam int T_DLY    = ROT_LAT - 4;
    localparam logic [CHI_W-1:0] ANG_ROUND = CHI_W'(48'h0000_8000_0000);

    logic [ANGLE_W-1:0] d2, d3, ang2, ang3;
    logic signed [ROT_W-1:0] sin2, sin3;

    logic [K4P_W-1:0] k4p_reg;
    logic [K3P_W-1:0] k3p_reg;
    logic [K2_W-1:0]  k2_d1_reg, k2_d2_reg;
    logic [K6P_W-1:0] k6p_reg;
    logic [K4_W-1:0]  k4_reg;
    logic [K3_W-1:0]  k3_reg;

    logic signed [M3_W-1:0]  m3_reg;
    logic signed [M5_W-1:0]  m5_reg;
    logic signed [MD_W-1:0]  md_reg;
    logic signed [MD_W-1:0]  m2_reg;
    logic signed [M3T_W-1:0] mt_reg;

    logic signed [CHI_W-1:0] poly_reg;
    logic signed [T2_W-1:0]  t2_reg;
    logic signed [T3_W-1:0]  t3_reg;
    logic signed [CHI_W-1:0] poly_line [POLY_DLY];
    logic signed [T2_W-1:0]  t2_line [T_DLY];
    logic signed [T3_W-1:0]  t3_line [T_DLY];

    logic signed [Q2_W-1:0]  q2_reg;
    logic signed [Q3_W-1:0]  q3_reg;
    logic signed [SQ_W-1:0]  s2q, s3q;
    logic [CHI_W-1:0]        chi_reg;
    logic [PL_W-1:0]         plo_full, phi_full;
    logic [CHI_W-1:0]        plo_reg;
    logic [HALF_CHI-1:0]     phi_reg;
    logic [CHI_W-1:0]        ang_sum;
    logic [ANGLE_W-1:0]      ang_reg;

    // astigmatism angles, 2(phi-a2) and 3(phi-a3) modulo a turn
    assign d2   = phi - cfg.twofold_angle;
    assign d3   = phi - cfg.threefold_angle;
    assign ang2 = {d2[ANGLE_W-2:0], 1'b0};
    assign ang3 = d3 + {d3[ANGLE_W-2:0], 1'b0};

    clabf_rot u_rot2 (
        .clk (clk),
        .ang (ang2),
        .cos (),
        .sin (sin2)
    );

    clabf_rot u_rot3 (
        .clk (clk),
        .ang (ang3),
        .cos (),
        .sin (sin3)
    );

    // k^4 and k^3, then k^6
    always_ff @(posedge clk)
    begin
        k4p_reg   <= k2 * k2;
        k3p_reg   <= k2 * k;
        k2_d1_reg <= k2;
        k6p_reg   <= k4p_reg[K4P_W-1:FRAC_SH] * k2_d1_reg;
        k4_reg    <= k4p_reg[K4P_W-1:FRAC_SH];
        k3_reg    <= k3p_reg[K3P_W-1:FRAC_SH];
        k2_d2_reg <= k2_d1_reg;
    end

    // coefficient products
    always_ff @(posedge clk)
    begin
        m3_reg <= cfg.third_order_coef * $signed({1'b0, k4_reg});
        m5_reg <= cfg.fifth_order_coef * $signed({1'b0, k6p_reg[K6P_W-1:FRAC_SH]});
        md_reg <= cfg.defocus_coef * $signed({1'b0, k2_d2_reg});
        m2_reg <= cfg.twofold_coef * $signed({1'b0, k2_d2_reg});
        mt_reg <= cfg.threefold_coef * $signed({1'b0, k3_reg});
    end

    // isotropic terms summed, astigmatism amplitudes kept apart
    always_ff @(posedge clk)
    begin
        poly_reg <= CHI_W'($signed(m3_reg[M3_W-1:FRAC_SH]))
                  + CHI_W'($signed(m5_reg[M5_W-1:FRAC_SH]))
                  - CHI_W'($signed(md_reg[MD_W-1:FRAC_SH]));
        t2_reg   <= m2_reg[MD_W-1:FRAC_SH];
        t3_reg   <= mt_reg[M3T_W-1:FRAC_SH];
    end

    // wait for the astigmatism sines
    always_ff @(posedge clk)
    begin
        poly_line[0] <= poly_reg;
        for (int i = 1; i < POLY_DLY; i++) begin
            poly_line[i] <= poly_line[i-1];
        end
        t2_line[0] <= t2_reg;
        t3_line[0] <= t3_reg;
        for (int i = 1; i < T_DLY; i++) begin
            t2_line[i] <= t2_line[i-1];
            t3_line[i] <= t3_line[i-1];
        end
    end

    assign s2q = sin2[ROT_W-1:SIN_DROP];
    assign s3q = sin3[ROT_W-1:SIN_DROP];

    // astigmatism terms and the full chi, modulo 2^48
    always_ff @(posedge clk)
    begin
        q2_reg  <= t2_line[T_DLY-1] * s2q;
        q3_reg  <= t3_line[T_DLY-1] * s3q;
        chi_reg <= poly_line[POLY_DLY-1]
                 + CHI_W'($signed(q2_reg[Q2_W-1:FRAC_SH]))
                 + CHI_W'($signed(q3_reg[Q3_W-1:FRAC_SH]));
    end

    // chi times the turn scale in two halves, rounded at bit 31
    assign plo_full = chi_reg[HALF_CHI-1:0] * TURN_SCALE;
    assign phi_full = chi_reg[CHI_W-1:HALF_CHI] * TURN_SCALE;
    assign ang_sum  = plo_reg + {phi_reg, {HALF_CHI{1'b0}}} + ANG_ROUND;

    always_ff @(posedge clk)
    begin
        plo_reg <= plo_full[CHI_W-1:0];
        phi_reg <= phi_full[HALF_CHI-1:0];
        ang_reg <= ang_sum[CHI_W-1 -: ANGLE_W];
    end

    assign ang = ang_reg;

endmodule
`default_nettype wire

### rtl/core/coherent_lens_aberration_filter.sv
// Top level: coherent lens aberration filter for one Fourier sample per beat.
// Throughput: one sample per cycle; busy never rises and results cannot be held off.
// The pipeline: input and k^2, square root, phase with astigmatism CORDIC, final CORDIC rotation,
// multiply, round, saturate; the angle CORDIC runs beside the root.
// Reset clears the configuration registers (limit zero: all samples outside) and valid bits.
`timescale 1ns / 1ps
`default_nettype none
module coherent_lens_aberration_filter (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire clabf_pkg::in_t                      item,
    output logic                                     done,
    output clabf_pkg::out_t                          result,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [clabf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [clabf_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import clabf_pkg::*;

    localparam int K2E_W   = 2 * FREQ_W;
    localparam int LIM_SH_W = LIMIT_W + FRAC_SH;
    localparam int CMP_W   = (K2E_W > LIM_SH_W) ? K2E_W : LIM_SH_W;
    localparam int PHI_DLY = 2 + SQRT_LAT - VEC_LAT;
    localparam int CS_T    = 2 + SQRT_LAT + PH_LAT + ROT_LAT;
    localparam int OUT_T   = CS_T + 3;
    localparam int PROD_W  = SAMPLE_W + ROT_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int Q_W     = SUM_W - ROT_FRAC;
    localparam logic signed [SUM_W-1:0] MAC_ROUND = SUM_W'(1) <<< (ROT_FRAC - 1);
    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    cfg_t cfg_reg;

    logic [OUT_T:0] vld_reg;

    logic signed [FREQ_W-1:0]   fx0_reg, fy0_reg;
    logic signed [SAMPLE_W-1:0] wr0_reg, wi0_reg;
    logic [FREQ_W-1:0]          ax, ay;
    logic [K2E_W-1:0]           sqx_reg, sqy_reg;
    logic [K2E_W-1:0]           k2e;
    logic [CMP_W-1:0]           k2e_ext, lim_ext;
    logic [SQ_IN_W-1:0]         k2e_reg;
    logic                       in2_reg;

    logic [ANGLE_W-1:0]  phi_raw;
    logic [ROOT_W-1:0]   k_root;
    logic [ANGLE_W-1:0]  phi_line [PHI_DLY];
    logic [K2_W-1:0]     k2_line [SQRT_LAT];
    logic [ANGLE_W-1:0]  chi_ang;
    logic signed [ROT_W-1:0] cos_f, sin_f;

    logic signed [SAMPLE_W-1:0] wr_line [CS_T];
    logic signed [SAMPLE_W-1:0] wi_line [CS_T];
    logic                       in_line [CS_T-2];

    logic signed [PROD_W-1:0] prc_reg, pis_reg, pic_reg, prs_reg;
    logic                     in63_reg, in64_reg;
    logic signed [SUM_W-1:0]  re_sum, im_sum;
    logic signed [Q_W-1:0]    re_q_reg, im_q_reg;
    out_t                     result_reg;

    function automatic logic signed [SAMPLE_W-1:0] sat(input logic signed [Q_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if ((&v[Q_W-1:SAMPLE_W-1]) || !(|v[Q_W-1:SAMPLE_W-1])) begin
            r = v[SAMPLE_W-1:0];
        end
        else begin
            r = v[Q_W-1] ? SAT_MIN : SAT_MAX;
        end
        return r;
    endfunction

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_APERTURE:    cfg_reg.aperture_k2_limit <= cfg_data[LIMIT_W-1:0];
                REG_THIRD:       cfg_reg.third_order_coef  <= cfg_data[COEF_W-1:0];
                REG_FIFTH:       cfg_reg.fifth_order_coef  <= cfg_data[COEF_W-1:0];
                REG_DEFOCUS:     cfg_reg.defocus_coef      <= cfg_data[COEF_W-1:0];
                REG_TWOFOLD:     cfg_reg.twofold_coef      <= cfg_data[COEF_W-1:0];
                REG_TWO_ANGLE:   cfg_reg.twofold_angle     <= cfg_data[ANGLE_W-1:0];
                REG_THREEFOLD:   cfg_reg.threefold_coef    <= cfg_data[COEF_W-1:0];
                REG_THREE_ANGLE: cfg_reg.threefold_angle   <= cfg_data[ANGLE_W-1:0];
                default:         ;
            endcase
        end
    end

    // valid bits travel alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            vld_reg <= {vld_reg[OUT_T-1:0], start && !busy};
        end
    end

    // input beat capture
    always_ff @(posedge clk)
    begin
        if (start && !busy) begin
            fx0_reg <= item.freq_x;
            fy0_reg <= item.freq_y;
            wr0_reg <= item.wave_real;
            wi0_reg <= item.wave_imag;
        end
    end

    // k^2 and the aperture test
    assign ax      = fx0_reg[FREQ_W-1] ? (~fx0_reg + 1'b1) : fx0_reg;
    assign ay      = fy0_reg[FREQ_W-1] ? (~fy0_reg + 1'b1) : fy0_reg;
    assign k2e     = sqx_reg + sqy_reg;
    assign k2e_ext = CMP_W'(k2e);
    assign lim_ext = CMP_W'({cfg_reg.aperture_k2_limit, {FRAC_SH{1'b0}}});

    always_ff @(posedge clk)
    begin
        sqx_reg <= ax * ax;
        sqy_reg <= ay * ay;
        k2e_reg <= k2e_ext[SQ_IN_W-1:0];
        in2_reg <= (k2e_ext < lim_ext);
    end

    clabf_vec u_vec (
        .clk (clk),
        .fx  (fx0_reg),
        .fy  (fy0_reg),
        .phi (phi_raw)
    );

    clabf_isqrt u_isqrt (
        .clk  (clk),
        .val  (k2e_reg),
        .root (k_root)
    );

    // line up angle and k^2 with the root
    always_ff @(posedge clk)
    begin
        phi_line[0] <= phi_raw;
        for (int i = 1; i < PHI_DLY; i++) begin
            phi_line[i] <= phi_line[i-1];
        end
        k2_line[0] <= k2e_reg[SQ_IN_W-1:FRAC_SH];
        for (int i = 1; i < SQRT_LAT; i++) begin
            k2_line[i] <= k2_line[i-1];
        end
    end

    clabf_phase u_phase (
        .clk (clk),
        .cfg (cfg_reg),
        .k2  (k2_line[SQRT_LAT-1]),
        .k   (k_root),
        .phi (phi_line[PHI_DLY-1]),
        .ang (chi_ang)
    );

    clabf_rot u_rot (
        .clk (clk),
        .ang (chi_ang),
        .cos (cos_f),
        .sin (sin_f)
    );

    // sample and aperture flag wait for exp(-i chi)
    always_ff @(posedge clk)
    begin
        wr_line[0] <= wr0_reg;
        wi_line[0] <= wi0_reg;
        for (int i = 1; i < CS_T; i++) begin
            wr_line[i] <= wr_line[i-1];
            wi_line[i] <= wi_line[i-1];
        end
        in_line[0] <= in2_reg;
        for (int i = 1; i < CS_T - 2; i++) begin
            in_line[i] <= in_line[i-1];
        end
    end

    // complex multiply, round, saturate
    assign re_sum = SUM_W'(prc_reg) + SUM_W'(pis_reg) + MAC_ROUND;
    assign im_sum = SUM_W'(pic_reg) - SUM_W'(prs_reg) + MAC_ROUND;

    always_ff @(posedge clk)
    begin
        prc_reg  <= wr_line[CS_T-1] * cos_f;
        pis_reg  <= wi_line[CS_T-1] * sin_f;
        pic_reg  <= wi_line[CS_T-1] * cos_f;
        prs_reg  <= wr_line[CS_T-1] * sin_f;
        in63_reg <= in_line[CS_T-3];
        re_q_reg <= re_sum[SUM_W-1:ROT_FRAC];
        im_q_reg <= im_sum[SUM_W-1:ROT_FRAC];
        in64_reg <= in63_reg;
        result_reg.filtered_real   <= in64_reg ? sat(re_q_reg) : '0;
        result_reg.filtered_imag   <= in64_reg ? sat(im_q_reg) : '0;
        result_reg.inside_aperture <= in64_reg;
    end

    assign done   = vld_reg[OUT_T];
    assign result = result_reg;

endmodule
`default_nettype wire

### dv/coherent_lens_aberration_filter_tb.sv
// Testbench for the lens aberration filter: queued driver, self-checking monitor, phased stimulus.
`timescale 1ns / 1ps
`default_nettype none
module coherent_lens_aberration_filter_tb;
    import clabf_pkg::*;

    localparam int  LATENCY     = 66;
    localparam int  SETTLE      = LATENCY + 20;
    localparam int  STALL_LIMIT = 4000;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'd12;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    in_t  item = '0;
    logic done;
    out_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    coherent_lens_aberration_filter dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    cfg_t lens_cfg = '0;
    in_t  sample_q[$];
    out_t filtered_q[$];
    int   send_idle = 0;
    int   errors = 0;
    int   n_inside = 0;
    int   n_outside = 0;
    int   n_saturated = 0;
    int   quiet_cycles = 0;

    // Binary angle per CORDIC step
    localparam longint ATAN_LUT [CORDIC_STEPS] = '{
        8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1
    };

    initial begin
        forever #6 clk = ~clk;
    end

    // Floor square root
    function automatic longint floor_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    // Vectoring CORDIC: binary angle of (y, x)
    function automatic logic [15:0] freq_angle(input longint y, input longint x);
        longint z;
        longint base;
        longint nx;
        z = 0;
        base = 0;
        if (x == 0 && y == 0) return 16'd0;
        if (x < 0) begin
            x = -x;
            y = -y;
            base = 32768;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += ATAN_LUT[i];
            end
            else begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= ATAN_LUT[i];
            end
            x = nx;
        end
        return 16'(base + z);
    endfunction

    // Rotation CORDIC: cosine and sine in Q.30
    function automatic void phase_sincos(input logic [15:0] a, output longint c,
                                         output longint s);
        longint z;
        longint x;
        longint y;
        longint nx;
        bit     neg;
        z = longint'(a);
        x = longint'(CORDIC_X0);
        y = 0;
        neg = 1'b0;
        if (z >= 32768) z -= 65536;
        if (z > 16384) begin
            z -= 32768;
            neg = 1'b1;
        end
        else if (z < -16384) begin
            z += 32768;
            neg = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= ATAN_LUT[i];
            end
            else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += ATAN_LUT[i];
            end
            x = nx;
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    function automatic logic signed [31:0] round_sat(input longint acc);
        longint v;
        v = (acc + (64'sd1 <<< 29)) >>> 30;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return 32'(v);
    endfunction

    // Expected filtered sample under the current lens settings
    function automatic out_t lens_filter(input in_t s);
        out_t   o;
        longint fx, fy, wr, wi, k2e, k2, k, k3, k4, k6, chi, t, c, sn;
        longint unsigned scaled;
        logic [15:0] phi, d, ang;
        o  = '0;
        fx = longint'($signed(s.freq_x));
        fy = longint'($signed(s.freq_y));
        wr = longint'($signed(s.wave_real));
        wi = longint'($signed(s.wave_imag));
        k2e = fx * fx + fy * fy;
        if (k2e >= (longint'(lens_cfg.aperture_k2_limit) << 20)) return o;
        k2 = k2e >>> 20;
        k  = floor_sqrt(longint'(k2e));
        k4 = (k2 * k2) >>> 20;
        k6 = (k4 * k2) >>> 20;
        k3 = (k2 * k) >>> 20;
        phi = freq_angle(fy, fx);
        chi = (longint'(lens_cfg.third_order_coef) * k4) >>> 20;
        chi += (longint'(lens_cfg.fifth_order_coef) * k6) >>> 20;
        chi -= (longint'(lens_cfg.defocus_coef) * k2) >>> 20;
        d = phi - lens_cfg.twofold_angle;
        ang = 16'(d * 2);
        phase_sincos(ang, c, sn);
        t = (longint'(lens_cfg.twofold_coef) * k2) >>> 20;
        chi += (t * (sn >>> 10)) >>> 20;
        d = phi - lens_cfg.threefold_angle;
        ang = 16'(d * 3);
        phase_sincos(ang, c, sn);
        t = (longint'(lens_cfg.threefold_coef) * k3) >>> 20;
        chi += (t * (sn >>> 10)) >>> 20;
        scaled = longint'(chi) * 64'd683565276 + (64'd1 << 31);
        ang = scaled[47:32];
        phase_sincos(ang, c, sn);
        o.filtered_real = round_sat(wr * c + wi * sn);
        o.filtered_imag = round_sat(wi * c - wr * sn);
        o.inside_aperture = 1'b1;
        return o;
    endfunction

    // Driver: takes the next queued sample, with random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end
        else begin
            if (start && !busy) filtered_q.push_back(lens_filter(item));
            if (!start || !busy) begin
                if (sample_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                    start <= 1'b1;
                    item  <= sample_q.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: result check, register shadow, watchdog
    always @(posedge clk) begin
        out_t want;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_APERTURE:    lens_cfg.aperture_k2_limit <= cfg_data[LIMIT_W-1:0];
                    REG_THIRD:       lens_cfg.third_order_coef  <= cfg_data;
                    REG_FIFTH:       lens_cfg.fifth_order_coef  <= cfg_data;
                    REG_DEFOCUS:     lens_cfg.defocus_coef      <= cfg_data;
                    REG_TWOFOLD:     lens_cfg.twofold_coef      <= cfg_data;
                    REG_TWO_ANGLE:   lens_cfg.twofold_angle     <= cfg_data[ANGLE_W-1:0];
                    REG_THREEFOLD:   lens_cfg.threefold_coef    <= cfg_data;
                    REG_THREE_ANGLE: lens_cfg.threefold_angle   <= cfg_data[ANGLE_W-1:0];
                    default: ;
                endcase
            end
            if (done) begin
                if (filtered_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected: %h", $time, result);
                    errors++;
                end
                else begin
                    want = filtered_q.pop_front();
                    if (want.inside_aperture) n_inside++;
                    else n_outside++;
                    if (want.filtered_real == 32'sh7fffffff
                        || want.filtered_real == -32'sh80000000
                        || want.filtered_imag == 32'sh7fffffff
                        || want.filtered_imag == -32'sh80000000)
                        n_saturated++;
                    if (result.filtered_real !== want.filtered_real) begin
                        $display("%0t: filtered_real expected %h got %h", $time,
                                 want.filtered_real, result.filtered_real);
                        errors++;
                    end
                    if (result.filtered_imag !== want.filtered_imag) begin
                        $display("%0t: filtered_imag expected %h got %h", $time,
                                 want.filtered_imag, result.filtered_imag);
                        errors++;
                    end
                    if (result.inside_aperture !== want.inside_aperture) begin
                        $display("%0t: inside_aperture expected %b got %b", $time,
                                 want.inside_aperture, result.inside_aperture);
                        errors++;
                    end
                end
            end
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: watchdog expired, %0d results outstanding", $time,
                         filtered_q.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Pause until every queued beat is through and the pipeline is empty
    task automatic drain();
        wait (sample_q.size() == 0 && !start && filtered_q.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic load_lens(input logic [23:0] lim, input logic [31:0] c3, c5, cd, c2,
                             input logic [15:0] a2, input logic [31:0] ct,
                             input logic [15:0] a3);
        write_reg(REG_APERTURE, {8'($urandom), lim});
        write_reg(REG_THIRD, c3);
        write_reg(REG_FIFTH, c5);
        write_reg(REG_DEFOCUS, cd);
        write_reg(REG_TWOFOLD, c2);
        write_reg(REG_TWO_ANGLE, {16'($urandom), a2});
        write_reg(REG_THREEFOLD, ct);
        write_reg(REG_THREE_ANGLE, {16'($urandom), a3});
    endtask

    function automatic in_t make_sample(input logic [23:0] x, y, input logic [31:0] re, im);
        in_t s;
        s.freq_x = x;
        s.freq_y = y;
        s.wave_real = re;
        s.wave_imag = im;
        return s;
    endfunction

    // Random sample: mostly frequencies of varied magnitude, some full range
    function automatic in_t random_sample();
        in_t s;
        int  r;
        s.freq_x = 24'($signed($urandom) >>> $urandom_range(8, 31));
        s.freq_y = 24'($signed($urandom) >>> $urandom_range(8, 31));
        if ($urandom_range(0, 9) == 0) begin
            s.freq_x = 24'($urandom);
            s.freq_y = 24'($urandom);
        end
        r = $urandom_range(0, 9);
        s.wave_real = (r < 7) ? 32'($urandom) : 32'($signed($urandom) >>> $urandom_range(0, 31));
        s.wave_imag = (r == 9) ? s.wave_real : 32'($urandom);
        return s;
    endfunction

    task automatic random_phase(input int count, input int idle);
        send_idle = idle;
        repeat (count) sample_q.push_back(random_sample());
        drain();
    endtask

    function automatic logic [31:0] rand_coef();
        return 32'($signed($urandom) >>> $urandom_range(0, 31));
    endfunction

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Limit at reset is zero: everything outside
        sample_q.push_back(make_sample(24'd0, 24'd0, 32'h7fffffff, 32'h80000000));
        sample_q.push_back(make_sample(24'h7fffff, 24'h800000, 32'h12345678, 32'hdeadbeef));
        drain();

        // Directed: largest limit, spherical, defocus and astigmatism terms, a write to an unmapped register
        load_lens(24'hffffff, 32'h0001_8000, 32'hfffe_0000, 32'h0003_4000,
                  32'h0000_c000, 16'h2000, 32'hffff_6000, 16'hc000);
        write_reg(REG_UNMAPPED, 32'hffffffff);
        sample_q.push_back(make_sample(24'd0, 24'd0, 32'h00010000, 32'hffff0000));
        sample_q.push_back(make_sample(24'h100000, 24'd0, 32'h00010000, 32'd0));
        sample_q.push_back(make_sample(24'hf00000, 24'd0, 32'h00010000, 32'd0));
        sample_q.push_back(make_sample(24'hf00000, 24'h080000, 32'h7fffffff, 32'h7fffffff));
        sample_q.push_back(make_sample(24'hf80000, 24'hf80000, 32'h80000000, 32'h80000000));
        sample_q.push_back(make_sample(24'd0, 24'h200000, 32'h7fffffff, 32'h80000000));
        sample_q.push_back(make_sample(24'd0, 24'he00000, 32'h80000000, 32'h7fffffff));
        sample_q.push_back(make_sample(24'h7fffff, 24'h7fffff, 32'h1, 32'h1));
        sample_q.push_back(make_sample(24'h800000, 24'h800000, 32'h1, 32'h1));
        sample_q.push_back(make_sample(24'h3fffff, 24'h000001, 32'hffffffff, 32'h0));
        sample_q.push_back(make_sample(24'hffffff, 24'h000001, 32'h0, 32'hffffffff));
        drain();

        // Directed: extreme coefficients and angles
        load_lens(24'h000400, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  32'h80000000, 16'hffff, 32'h7fffffff, 16'h0001);
        for (int i = 0; i < 8; i++)
            sample_q.push_back(make_sample(24'(i * 24'h0001c0 - 24'h000700), 24'(24'h0003a0 - i * 24'h0000e0),
                                           32'h7fffffff, 32'h7fffffff));
        drain();

        // Random phases across several lens settings and idling patterns
        load_lens(24'hffffff, rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                  16'($urandom), rand_coef(), 16'($urandom));
        random_phase(300, 0);
        load_lens(24'($urandom_range(1, 32) << 16), rand_coef(), rand_coef(), rand_coef(),
                  rand_coef(), 16'($urandom), rand_coef(), 16'($urandom));
        random_phase(300, 86);
        load_lens(24'($urandom), 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  16'h0000, 32'h80000000, 16'hffff);
        random_phase(300, 37);
        load_lens(24'h000000, rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                  16'($urandom), rand_coef(), 16'($urandom));
        random_phase(100, 0);
        load_lens(24'($urandom_range(1, 255) << 12), 32'($urandom), 32'($urandom),
                  32'($urandom), 32'($urandom), 16'($urandom), 32'($urandom), 16'($urandom));
        random_phase(250, 86);
        load_lens(24'hffffff, rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                  16'($urandom), rand_coef(), 16'($urandom));
        random_phase(280, 0);

        $display("Checked %0d samples inside the aperture and %0d outside, %0d saturated,",
                 n_inside, n_outside, n_saturated);
        $display("over eight lens settings with bursts and sparse input.");
        if (errors == 0 && filtered_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire
